>>> rtl/vu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Video unit package
// Shared codes, constants, the word passed between the front and back parts
// of the video unit register file and the finished result word.
// ----------------------------------------------------------------------------
package vu_pkg;

  // Operation codes of an input word.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // CPU-visible register indexes.
  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_MASK   = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_OAMADR = 3'd3;
  localparam logic [2:0] REG_OAMDAT = 3'd4;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR   = 3'd6;
  localparam logic [2:0] REG_DATA   = 3'd7;

  // Error codes of a result word.
  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_REG  = 2'd1;
  localparam logic [1:0] ERR_ADDR = 2'd2;

  // Raster timing.
  localparam logic [8:0] DOTS_PER_LINE  = 9'd341;
  localparam logic [8:0] VBLANK_LINE    = 9'd241;
  localparam logic [8:0] LINES_PER_FRAME = 9'd262;

  // Sprite memory geometry.
  localparam int SPRITE_BYTES = 256;
  localparam int SPR_AW       = $clog2(SPRITE_BYTES);

  // Result queue geometry.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // How the back part finishes a word.
  typedef enum logic [1:0] {
    KIND_PLAIN  = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_SPRITE = 2'd2,
    KIND_NTREAD = 2'd3
  } vu_kind_t;

  // Word handed from the front part to the back part.
  typedef struct packed {
    logic [7:0]  rv;
    logic [1:0]  err;
    logic        nmi;
    logic        done;
    logic        preq;
    logic [12:0] paddr;
    logic [8:0]  line;
    logic [8:0]  dot;
    vu_kind_t    kind;
    logic        spr_vld;
  } vu_entry_t;

  // Finished result word.
  typedef struct packed {
    logic [7:0]  read_value;
    logic [1:0]  error_code;
    logic        nmi_pulse;
    logic        frame_done;
    logic        pattern_request;
    logic [12:0] pattern_address;
    logic [8:0]  line_now;
    logic [8:0]  dot_now;
  } vu_result_t;

endpackage

>>> rtl/vu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Video unit channel interfaces
// Input, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface vu_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [2:0] register_index;
  logic [7:0] write_value;
  modport source (output valid, operation, register_index, write_value, input ready);
  modport sink   (input valid, operation, register_index, write_value, output ready);
endinterface

interface vu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_value;
  logic [1:0]  error_code;
  logic        nmi_pulse;
  logic        frame_done;
  logic        pattern_request;
  logic [12:0] pattern_address;
  logic [8:0]  line_now;
  logic [8:0]  dot_now;
  modport source (output valid, read_value, error_code, nmi_pulse, frame_done,
                  pattern_request, pattern_address, line_now, dot_now, input ready);
  modport sink   (input valid, read_value, error_code, nmi_pulse, frame_done,
                  pattern_request, pattern_address, line_now, dot_now, output ready);
endinterface

interface vu_cfg_if;
  logic valid;
  logic ready;
  logic mirror_mode;
  modport source (output valid, mirror_mode, input ready);
  modport sink   (input valid, mirror_mode, output ready);
endinterface

>>> rtl/video_unit_register_file_and_timing_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Video unit register file and timing, top level
// CPU register file and dot/scanline counters of a tile video unit.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one word per handshake: a dot tick, a register write or a
//   register read. out_if returns exactly one result word for each input
//   word, in order. cfg_if writes the mirroring mode; the user must do so
//   only while the unit is idle, which the block does not enforce. A word's
//   result passes the word register and the result queue before it is
//   offered. One word is taken every cycle while in_if.ready is high, with
//   one access per memory port. After reset a clearing pass zeroes every
//   nametable entry, one per cycle; in_if.ready stays low meanwhile.
//   Configuration writes are taken at any time.
//   When the receiver stalls, a four-entry result queue absorbs the words
//   in flight and in_if.ready drops before it can overflow.
// ----------------------------------------------------------------------------
module video_unit_register_file_and_timing_top
  import vu_pkg::*;
#(
  parameter int NAMETABLE_BYTES = 2048
) (
  input  logic     clk,
  input  logic     rst_n,
  vu_in_if.sink    in_if,
  vu_out_if.source out_if,
  vu_cfg_if.sink   cfg_if
);

  localparam int NT_AW = $clog2(NAMETABLE_BYTES);

  logic              room;
  logic              s1_valid;
  vu_entry_t         s1_entry;
  logic              spr_we;
  logic [SPR_AW-1:0] spr_waddr;
  logic [7:0]        spr_wdata;
  logic [SPR_AW-1:0] spr_raddr;
  logic [7:0]        spr_rdata;
  logic              nt_we;
  logic [NT_AW-1:0]  nt_waddr;
  logic [7:0]        nt_wdata;
  logic [NT_AW-1:0]  nt_raddr;
  logic [7:0]        nt_rdata;

  // Front part: decode and state.
  vu_front #(.NAMETABLE_BYTES(NAMETABLE_BYTES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if),
    .cfg_ch     (cfg_if),
    .room       (room),
    .s1_valid_r (s1_valid),
    .s1_entry_r (s1_entry),
    .spr_we     (spr_we),
    .spr_waddr  (spr_waddr),
    .spr_wdata  (spr_wdata),
    .spr_raddr  (spr_raddr),
    .nt_we      (nt_we),
    .nt_waddr   (nt_waddr),
    .nt_wdata   (nt_wdata),
    .nt_raddr   (nt_raddr)
  );

  // Sprite attribute memory.
  vu_ram #(.WIDTH(8), .DEPTH(SPRITE_BYTES)) u_spr_ram (
    .clk   (clk),
    .we    (spr_we),
    .waddr (spr_waddr),
    .wdata (spr_wdata),
    .raddr (spr_raddr),
    .rdata (spr_rdata)
  );

  // Nametable memory.
  vu_ram #(.WIDTH(8), .DEPTH(NAMETABLE_BYTES)) u_nt_ram (
    .clk   (clk),
    .we    (nt_we),
    .waddr (nt_waddr),
    .wdata (nt_wdata),
    .raddr (nt_raddr),
    .rdata (nt_rdata)
  );

  // Back part: completion and result queue.
  vu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_entry  (s1_entry),
    .spr_rdata (spr_rdata),
    .nt_rdata  (nt_rdata),
    .room      (room),
    .out_ch    (out_if)
  );

endmodule

>>> rtl/vu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/vu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Video unit front part
// Accepts words, keeps the register and raster state, issues memory
// accesses and hands a classified word to the back part.
// ----------------------------------------------------------------------------
module vu_front
  import vu_pkg::*;
#(
  parameter int NAMETABLE_BYTES = 2048
) (
  input  logic                               clk,
  input  logic                               rst_n,
  vu_in_if.sink                              in_ch,
  vu_cfg_if.sink                             cfg_ch,
  input  logic                               room,
  output logic                               s1_valid_r,
  output vu_entry_t                          s1_entry_r,
  output logic                               spr_we,
  output logic [SPR_AW-1:0]                  spr_waddr,
  output logic [7:0]                         spr_wdata,
  output logic [SPR_AW-1:0]                  spr_raddr,
  output logic                               nt_we,
  output logic [$clog2(NAMETABLE_BYTES)-1:0] nt_waddr,
  output logic [7:0]                         nt_wdata,
  output logic [$clog2(NAMETABLE_BYTES)-1:0] nt_raddr
);

  localparam int NT_AW = $clog2(NAMETABLE_BYTES);

  logic              mirror_r;
  logic [7:0]        ctrl_r,   ctrl_nxt;
  logic              vblank_r, vblank_nxt;
  logic [SPR_AW-1:0] oam_r,    oam_nxt;
  logic [15:0]       vaddr_r,  vaddr_nxt;
  logic              latch_r,  latch_nxt;
  logic [8:0]        line_r,   line_nxt;
  logic [8:0]        dot_r,    dot_nxt;
  logic [SPRITE_BYTES-1:0] spr_vld_r;
  logic              clr_busy_r;
  logic [NT_AW-1:0]  clr_cnt_r;
  logic              accept;
  vu_entry_t         entry;
  logic [8:0]        dot_inc;
  logic [8:0]        line_inc;
  logic [10:0]       nt_idx;
  logic              in_nt;
  logic              data_we;
  logic [15:0]       vaddr_step;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !clr_busy_r && room;
  assign accept       = in_ch.valid && in_ch.ready;

  // Nametable folding through the mirroring mode.
  always_comb begin
    nt_idx = {mirror_r ? vaddr_r[10] : vaddr_r[11], vaddr_r[9:0]};
  end

  assign in_nt      = (vaddr_r >= 16'h2000) && (vaddr_r <= 16'h2FFF);
  assign vaddr_step = vaddr_r + (ctrl_r[2] ? 16'd32 : 16'd1);
  assign dot_inc    = dot_r + 9'd1;
  assign line_inc   = line_r + 9'd1;

  // Decode of the accepted word and next state.
  always_comb begin
    ctrl_nxt   = ctrl_r;
    vblank_nxt = vblank_r;
    oam_nxt    = oam_r;
    vaddr_nxt  = vaddr_r;
    latch_nxt  = latch_r;
    line_nxt   = line_r;
    dot_nxt    = dot_r;
    data_we    = 1'b0;
    spr_we     = 1'b0;
    entry      = '0;
    entry.kind = KIND_PLAIN;
    if (accept) begin
      unique case (in_ch.operation)
        OP_TICK: begin
          if (dot_inc >= DOTS_PER_LINE) begin
            dot_nxt  = '0;
            line_nxt = line_inc;
            if (line_inc == VBLANK_LINE) begin
              vblank_nxt = 1'b1;
              entry.nmi  = ctrl_r[7];
            end else if (line_inc >= LINES_PER_FRAME) begin
              line_nxt   = '0;
              vblank_nxt = 1'b0;
              entry.done = 1'b1;
            end
          end else begin
            dot_nxt = dot_inc;
          end
        end
        OP_WRITE: begin
          unique case (in_ch.register_index)
            REG_CTRL: begin
              ctrl_nxt  = in_ch.write_value;
              entry.nmi = !ctrl_r[7] && in_ch.write_value[7] && vblank_r;
            end
            REG_OAMADR: oam_nxt = in_ch.write_value;
            REG_OAMDAT: begin
              spr_we  = 1'b1;
              oam_nxt = oam_r + 8'd1;
            end
            REG_SCROLL: latch_nxt = !latch_r;
            REG_ADDR: begin
              if (!latch_r) begin
                vaddr_nxt = {in_ch.write_value, vaddr_r[7:0]};
              end else begin
                vaddr_nxt = {vaddr_r[15:8], in_ch.write_value};
              end
              latch_nxt = !latch_r;
            end
            REG_DATA: begin
              data_we   = in_nt;
              entry.err = in_nt ? ERR_OK : ERR_ADDR;
              vaddr_nxt = vaddr_step;
            end
            REG_MASK: ;
            default: entry.err = ERR_REG;
          endcase
        end
        OP_READ: begin
          unique case (in_ch.register_index)
            REG_STATUS: begin
              entry.kind = KIND_STATUS;
              entry.rv   = {vblank_r, 1'b0, 1'b1, 5'd0};
              vblank_nxt = 1'b0;
              latch_nxt  = 1'b0;
            end
            REG_OAMDAT: begin
              entry.kind    = KIND_SPRITE;
              entry.spr_vld = spr_vld_r[oam_r];
            end
            REG_DATA: begin
              if (vaddr_r <= 16'h1FFF) begin
                entry.preq  = 1'b1;
                entry.paddr = vaddr_r[12:0];
              end else if (vaddr_r <= 16'h2FFF) begin
                entry.kind = KIND_NTREAD;
              end else begin
                entry.err = ERR_ADDR;
              end
              vaddr_nxt = vaddr_step;
            end
            default: entry.err = ERR_REG;
          endcase
        end
        default: entry.err = ERR_REG;
      endcase
    end
    entry.line = line_nxt;
    entry.dot  = dot_nxt;
  end

  // Memory port drive; the clearing pass owns the nametable after reset.
  assign spr_waddr = oam_r;
  assign spr_wdata = in_ch.write_value;
  assign spr_raddr = oam_r;
  assign nt_we     = clr_busy_r || data_we;
  assign nt_waddr  = clr_busy_r ? clr_cnt_r : NT_AW'(nt_idx);
  assign nt_wdata  = clr_busy_r ? 8'd0 : in_ch.write_value;
  assign nt_raddr  = NT_AW'(nt_idx);

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_r   <= 1'b0;
      ctrl_r     <= '0;
      vblank_r   <= 1'b1;
      oam_r      <= '0;
      vaddr_r    <= '0;
      latch_r    <= 1'b0;
      line_r     <= '0;
      dot_r      <= '0;
      spr_vld_r  <= '0;
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        mirror_r <= cfg_ch.mirror_mode;
      end
      ctrl_r     <= ctrl_nxt;
      vblank_r   <= vblank_nxt;
      oam_r      <= oam_nxt;
      vaddr_r    <= vaddr_nxt;
      latch_r    <= latch_nxt;
      line_r     <= line_nxt;
      dot_r      <= dot_nxt;
      if (spr_we) begin
        spr_vld_r[oam_r] <= 1'b1;
      end
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == NT_AW'(NAMETABLE_BYTES - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      s1_valid_r <= accept;
    end
  end

  // Word register toward the back part.
  always_ff @(posedge clk) begin
    s1_entry_r <= entry;
  end

endmodule

>>> rtl/vu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Video unit back part
// Completes each word with memory read data and the read buffer, and
// queues the finished results for the output channel.
// ----------------------------------------------------------------------------
module vu_back
  import vu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       s1_valid,
  input  vu_entry_t  s1_entry,
  input  logic [7:0] spr_rdata,
  input  logic [7:0] nt_rdata,
  output logic       room,
  vu_out_if.source   out_ch
);

  logic [7:0]     rbuf_r, rbuf_nxt;
  vu_result_t     res;
  vu_result_t     q_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   cnt_r;
  logic           pop;

  // Result assembly.
  always_comb begin
    rbuf_nxt            = rbuf_r;
    res.read_value      = s1_entry.rv;
    res.error_code      = s1_entry.err;
    res.nmi_pulse       = s1_entry.nmi;
    res.frame_done      = s1_entry.done;
    res.pattern_request = s1_entry.preq;
    res.pattern_address = s1_entry.paddr;
    res.line_now        = s1_entry.line;
    res.dot_now         = s1_entry.dot;
    case (s1_entry.kind)
      KIND_STATUS: res.read_value = s1_entry.rv | {3'd0, rbuf_r[4:0]};
      KIND_SPRITE: res.read_value = s1_entry.spr_vld ? spr_rdata : 8'd0;
      KIND_NTREAD: begin
        res.read_value = rbuf_r;
        if (s1_valid) begin
          rbuf_nxt = nt_rdata;
        end
      end
      default: ;
    endcase
  end

  assign pop          = out_ch.valid && out_ch.ready;
  assign out_ch.valid = cnt_r != '0;
  assign room         = (cnt_r + {{QAW{1'b0}}, s1_valid}) <= (QAW+1)'(QDEPTH - 1);

  assign out_ch.read_value      = q_r[rd_ptr_r].read_value;
  assign out_ch.error_code      = q_r[rd_ptr_r].error_code;
  assign out_ch.nmi_pulse       = q_r[rd_ptr_r].nmi_pulse;
  assign out_ch.frame_done      = q_r[rd_ptr_r].frame_done;
  assign out_ch.pattern_request = q_r[rd_ptr_r].pattern_request;
  assign out_ch.pattern_address = q_r[rd_ptr_r].pattern_address;
  assign out_ch.line_now        = q_r[rd_ptr_r].line_now;
  assign out_ch.dot_now         = q_r[rd_ptr_r].dot_now;

  // Queue control and read buffer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rbuf_r   <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      rbuf_r <= rbuf_nxt;
      if (s1_valid) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + {{QAW{1'b0}}, s1_valid} - {{QAW{1'b0}}, pop};
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      q_r[wr_ptr_r] <= res;
    end
  end

endmodule
